>>> design/lags_pkg.sv
// Shared constants, types and functions of the life generation stream.
package lags_pkg;

    localparam int WORD_CELLS  = 32;
    localparam int MAX_WORDS   = 8;
    localparam int MAX_ROWS    = 256;
    localparam int WORD_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW_W        = 4;
    localparam int NR_W        = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = NR_W;
    localparam int BANKS       = 3;
    localparam int BANK_W      = 2;
    localparam int MEM_DEPTH   = BANKS * MAX_WORDS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;

    localparam logic [NW_W-1:0] NW_RESET = NW_W'((MAX_WORDS < 8) ? MAX_WORDS : 8);
    localparam logic [NR_W-1:0] NR_RESET = NR_W'((MAX_ROWS < 192) ? MAX_ROWS : 192);

    typedef enum logic [1:0] {
        FS_RUN   = 2'b01,
        FS_FLUSH = 2'b10
    } t_fstate;

    typedef struct packed {
        logic [WORD_CELLS-1:0] cells;
        logic [ROW_W-1:0]      row;
        logic [WORD_W-1:0]     step;
        logic                  use_up;
        logic                  use_mid;
        logic                  emit_prev;
        logic                  emit_last;
        logic                  frame_end;
        logic                  run_last;
    } t_token;

    typedef struct packed {
        logic [WORD_CELLS-1:0] u0;
        logic [WORD_CELLS-1:0] m0;
        logic [WORD_CELLS-1:0] d0;
        logic [WORD_CELLS-1:0] u1;
        logic [WORD_CELLS-1:0] m1;
        logic [WORD_CELLS-1:0] d1;
        logic                  u2;
        logic                  m2;
        logic                  d2;
        logic [ROW_W-1:0]      row;
        logic [WORD_W-1:0]     step;
        logic                  emit_prev;
        logic                  emit_last;
        logic                  frame_end;
        logic                  run_last;
    } t_entry;

    function automatic logic [ADDR_W-1:0] lags_addr(input logic [BANK_W-1:0] bank,
                                                   input logic [WORD_W-1:0] word);
        return ADDR_W'(bank) * ADDR_W'(MAX_WORDS) + ADDR_W'(word);
    endfunction

    function automatic logic [BANK_W-1:0] lags_bank_back(input logic [BANK_W-1:0] b,
                                                        input logic [BANK_W-1:0] k);
        logic [BANK_W:0] s;
        s = (BANK_W+1)'(b) + (BANK_W+1)'(BANKS) - (BANK_W+1)'(k);
        return (s >= (BANK_W+1)'(BANKS)) ? BANK_W'(s - (BANK_W+1)'(BANKS)) : BANK_W'(s);
    endfunction

    // bit 0 is the left neighbor cell, the top bit the right neighbor cell
    function automatic logic [WORD_CELLS-1:0] lags_life(input logic [WORD_CELLS+1:0] up,
                                                       input logic [WORD_CELLS+1:0] mid,
                                                       input logic [WORD_CELLS+1:0] dn);
        logic [3:0]            n;
        logic [WORD_CELLS-1:0] res;
        res = '0;
        for (int i = 0; i < WORD_CELLS; i++) begin
            n = 4'(up[i]) + 4'(up[i+1]) + 4'(up[i+2]) + 4'(mid[i]) + 4'(mid[i+2])
              + 4'(dn[i]) + 4'(dn[i+1]) + 4'(dn[i+2]);
            res[i] = (n == 4'd3) || (mid[i+1] && (n == 4'd2));
        end
        return res;
    endfunction

endpackage

>>> design/lags_item_if.sv
// Input channel carrying one word of the current generation per beat.
interface lags_item_if import lags_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [WORD_CELLS-1:0] cells;

    modport source (output valid, output cells, input ready);
    modport sink (input valid, input cells, output ready);
endinterface

>>> design/lags_result_if.sv
// Output channel carrying one next-generation word per beat.
interface lags_result_if import lags_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [WORD_CELLS-1:0] next_cells;
    logic [ROW_W-1:0]      out_row;
    logic [WORD_W-1:0]     out_word;
    logic                  frame_end;
    logic                  run_last;

    modport source (output valid, output next_cells, output out_row, output out_word,
                    output frame_end, output run_last, input ready);
    modport sink (input valid, input next_cells, input out_row, input out_word,
                  input frame_end, input run_last, output ready);
endinterface

>>> design/lags_fifo.sv
// Short queue of neighborhood entries between the front and back parts.
module lags_fifo import lags_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_entry            i_wdata,
    input  logic              i_pop,
    output logic              o_valid,
    output t_entry            o_rdata,
    output logic [QCNT_W-1:0] o_count
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

>>> design/lags_front.sv
// Front part: accepts beats, keeps the line buffers and builds neighborhood entries.
module lags_front import lags_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lags_item_if.sink             i_item,
    input  logic [QCNT_W-1:0]     i_q_count,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [WORD_CELLS-1:0] r_mem [MEM_DEPTH];
    logic [WORD_CELLS-1:0] r_rd0;
    logic [WORD_CELLS-1:0] r_rd1;

    logic [NW_W-1:0]       r_nw;
    logic [NR_W-1:0]       r_rows;
    logic [ROW_W-1:0]      r_row;
    logic [WORD_W-1:0]     r_word;
    logic [ROW_W-1:0]      r_frow;
    logic [WORD_W-1:0]     r_fcol;
    logic                  r_fup;
    logic [BANK_W-1:0]     r_bank;
    t_fstate               r_state;

    logic                  r_b_valid;
    t_token                r_b;
    t_token                n_b;

    logic [WORD_CELLS-1:0] r_pu, r_pm, r_pd;
    logic                  r_qu, r_qm, r_qd;

    logic                  space_ok;
    logic                  accept;
    logic                  flush_go;
    logic                  word_last;
    logic                  row_last;
    logic                  fcol_last;
    logic                  row_ge1;
    logic                  row_ge2;
    logic [BANK_W-1:0]     bank_mid;
    logic [BANK_W-1:0]     bank_up;
    logic [ADDR_W-1:0]     rd_addr0;
    logic [ADDR_W-1:0]     rd_addr1;
    logic [ADDR_W-1:0]     wr_addr;
    logic [NW_W-1:0]       nw_sat;
    logic [NR_W-1:0]       rows_sat;
    logic                  first;
    logic [WORD_CELLS-1:0] nu, nm, nd;
    logic [WORD_CELLS-1:0] pu, pm, pd;

    assign space_ok  = (QCNT_W'(i_q_count) + QCNT_W'(r_b_valid)) < QCNT_W'(QUEUE_DEPTH);
    assign i_item.ready = (r_state == FS_RUN) && space_ok;
    assign accept    = i_item.valid && i_item.ready;
    assign flush_go  = (r_state == FS_FLUSH) && space_ok;

    assign word_last = (NW_W'(r_word) + NW_W'(1)) >= r_nw;
    assign row_last  = (NR_W'(r_row) + NR_W'(1)) >= r_rows;
    assign fcol_last = (NW_W'(r_fcol) + NW_W'(1)) >= r_nw;
    assign row_ge1   = (r_row != '0);
    assign row_ge2   = (r_row > ROW_W'(1));

    assign bank_mid  = lags_bank_back(r_bank, BANK_W'(1));
    assign bank_up   = lags_bank_back(r_bank, BANK_W'(2));
    assign rd_addr0  = (r_state == FS_FLUSH) ? lags_addr(bank_mid, r_fcol)
                                             : lags_addr(bank_up, r_word);
    assign rd_addr1  = (r_state == FS_FLUSH) ? lags_addr(r_bank, r_fcol)
                                             : lags_addr(bank_mid, r_word);
    assign wr_addr   = lags_addr(r_bank, r_word);

    always_comb begin
        nw_sat = i_cfg_wdata[NW_W-1:0];
        if (nw_sat == '0) begin
            nw_sat = NW_W'(1);
        end else if (nw_sat > NW_W'(MAX_WORDS)) begin
            nw_sat = NW_W'(MAX_WORDS);
        end
        rows_sat = i_cfg_wdata[NR_W-1:0];
        if (rows_sat == '0) begin
            rows_sat = NR_W'(1);
        end else if (rows_sat > NR_W'(MAX_ROWS)) begin
            rows_sat = NR_W'(MAX_ROWS);
        end
    end

    always_comb begin
        if (r_state == FS_FLUSH) begin
            n_b.cells     = '0;
            n_b.row       = r_frow;
            n_b.step      = r_fcol;
            n_b.use_up    = r_fup;
            n_b.use_mid   = 1'b1;
            n_b.emit_prev = (r_fcol != '0);
            n_b.emit_last = fcol_last;
            n_b.frame_end = fcol_last;
            n_b.run_last  = fcol_last;
        end else begin
            n_b.cells     = i_item.cells;
            n_b.row       = r_row - ROW_W'(1);
            n_b.step      = r_word;
            n_b.use_up    = row_ge2;
            n_b.use_mid   = row_ge1;
            n_b.emit_prev = row_ge1 && (r_word != '0);
            n_b.emit_last = row_ge1 && word_last;
            n_b.frame_end = 1'b0;
            n_b.run_last  = !(word_last && row_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wr_addr] <= i_item.cells;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nw      <= NW_RESET;
            r_rows    <= NR_RESET;
            r_row     <= '0;
            r_word    <= '0;
            r_fcol    <= '0;
            r_frow    <= '0;
            r_fup     <= 1'b0;
            r_bank    <= '0;
            r_state   <= FS_RUN;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept || flush_go;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WORDS: begin
                        r_nw   <= nw_sat;
                        r_row  <= '0;
                        r_word <= '0;
                    end
                    CFG_ROWS: begin
                        r_rows <= rows_sat;
                        r_row  <= '0;
                        r_word <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                if (word_last) begin
                    r_word <= '0;
                    if (row_last) begin
                        r_row   <= '0;
                        r_state <= FS_FLUSH;
                        r_fcol  <= '0;
                        r_frow  <= r_row;
                        r_fup   <= row_ge1;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_bank <= bank_up;
                    end
                end else begin
                    r_word <= r_word + WORD_W'(1);
                end
            end else if (flush_go) begin
                if (fcol_last) begin
                    r_state <= FS_RUN;
                end else begin
                    r_fcol <= r_fcol + WORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept || flush_go) begin
            r_b <= n_b;
        end
    end

    assign nu    = r_b.use_up ? r_rd0 : '0;
    assign nm    = r_b.use_mid ? r_rd1 : '0;
    assign nd    = r_b.cells;
    assign first = (r_b.step == '0);
    assign pu    = first ? '0 : r_pu;
    assign pm    = first ? '0 : r_pm;
    assign pd    = first ? '0 : r_pd;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_pu <= nu;
            r_pm <= nm;
            r_pd <= nd;
            r_qu <= pu[WORD_CELLS-1];
            r_qm <= pm[WORD_CELLS-1];
            r_qd <= pd[WORD_CELLS-1];
        end
    end

    always_comb begin
        o_entry.u0        = nu;
        o_entry.m0        = nm;
        o_entry.d0        = nd;
        o_entry.u1        = pu;
        o_entry.m1        = pm;
        o_entry.d1        = pd;
        o_entry.u2        = !first && r_qu;
        o_entry.m2        = !first && r_qm;
        o_entry.d2        = !first && r_qd;
        o_entry.row       = r_b.row;
        o_entry.step      = r_b.step;
        o_entry.emit_prev = r_b.emit_prev;
        o_entry.emit_last = r_b.emit_last;
        o_entry.frame_end = r_b.frame_end;
        o_entry.run_last  = r_b.run_last;
    end

    assign o_push = r_b_valid && (r_b.emit_prev || r_b.emit_last);

endmodule

>>> design/lags_back.sv
// Back part: applies the B3/S23 rule to queued neighborhoods and drives the output register.
module lags_back import lags_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  t_entry         i_head,
    output logic           o_pop,
    lags_result_if.source  o_result
);

    logic                  r_ov;
    logic                  r_done_a;
    logic [WORD_CELLS-1:0] r_next;
    logic [ROW_W-1:0]      r_row;
    logic [WORD_W-1:0]     r_word;
    logic                  r_fe;
    logic                  r_rl;

    logic                  job_a;
    logic                  load;
    logic [WORD_CELLS+1:0] up, mid, dn;

    assign job_a = i_head.emit_prev && !r_done_a;
    assign load  = i_q_valid && (!r_ov || o_result.ready);
    assign o_pop = load && !(job_a && i_head.emit_last);

    always_comb begin
        if (job_a) begin
            up  = {i_head.u0[0], i_head.u1, i_head.u2};
            mid = {i_head.m0[0], i_head.m1, i_head.m2};
            dn  = {i_head.d0[0], i_head.d1, i_head.d2};
        end else begin
            up  = {1'b0, i_head.u0, i_head.u1[WORD_CELLS-1]};
            mid = {1'b0, i_head.m0, i_head.m1[WORD_CELLS-1]};
            dn  = {1'b0, i_head.d0, i_head.d1[WORD_CELLS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_done_a <= 1'b0;
        end else if (load) begin
            r_ov     <= 1'b1;
            r_done_a <= job_a && i_head.emit_last;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_next <= lags_life(up, mid, dn);
            r_row  <= i_head.row;
            r_word <= job_a ? i_head.step - WORD_W'(1) : i_head.step;
            r_fe   <= !job_a && i_head.frame_end;
            r_rl   <= job_a ? (i_head.run_last && !i_head.emit_last) : i_head.run_last;
        end
    end

    assign o_result.valid      = r_ov;
    assign o_result.next_cells = r_next;
    assign o_result.out_row    = r_row;
    assign o_result.out_word   = r_word;
    assign o_result.frame_end  = r_fe;
    assign o_result.run_last   = r_rl;

endmodule

>>> design/life_automaton_generation_stream.sv
// Top level: streaming one-generation Conway B3/S23 engine over a raster bit grid.
// Path: an accepted input beat is registered in the front token register, then queued,
// then registered in the back output register; a pair of beats comes from one entry.
// Throughput: one input beat per cycle while the queue has room, one result beat per
// cycle while the output is ready, set by the back part's single rule unit; after a frame's
// last beat the front sweeps the final row from its two buffer read ports, taking no beat.
// Reset: counters zero, words_per_row 8, row_total 192; line buffers are not cleared.
module life_automaton_generation_stream import lags_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lags_item_if.sink             i_item,
    lags_result_if.source         o_result
);

    logic              q_push;
    t_entry            q_wdata;
    logic              q_pop;
    logic              q_valid;
    t_entry            q_head;
    logic [QCNT_W-1:0] q_count;

    lags_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_entry     (q_wdata)
    );

    lags_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_head),
        .o_count (q_count)
    );

    lags_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || q_pop)
        else $error("entry pushed into a full queue");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.frame_end |-> o_result.run_last)
        else $error("frame end beat is not the last of its run");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule
